@@ sv/interval_set_insert_merge_unit_defines.svh @@
// assertion macros for the interval set insert/merge unit
// used by files that take this header by include; needs clk and rst_n in scope
`ifndef INTERVAL_SET_INSERT_MERGE_UNIT_DEFINES_SVH
`define INTERVAL_SET_INSERT_MERGE_UNIT_DEFINES_SVH

// expression must hold at every clock edge outside reset
`define ISIM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ISIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/isim_pkg.sv @@
// shared constants, codes and types of the interval set insert/merge unit
// no dependencies; used by isim_cell, isim_array and the top level
`timescale 1ns / 1ps
`default_nettype none

package isim_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int DATA_W        = 32;
    localparam int POS_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W         = (CNT_W > 4) ? CNT_W : 4;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_BAD_ORDER = 2'd3;

    // row modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_ABSORB = 2'd2;

    // per-cell actions
    localparam logic [2:0] ACT_HOLD         = 3'd0;
    localparam logic [2:0] ACT_LOAD_NEW     = 3'd1;
    localparam logic [2:0] ACT_FROM_LEFT    = 3'd2;
    localparam logic [2:0] ACT_MERGE_NEW    = 3'd3;
    localparam logic [2:0] ACT_ABSORB_RIGHT = 3'd4;
    localparam logic [2:0] ACT_FROM_RIGHT   = 3'd5;

    typedef struct packed {
        logic precedes;
        logic overlap;
    } isim_flags_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             full;
        logic [POS_W-1:0] first_pos;
    } isim_ctrl_t;

    typedef struct packed {
        logic             any_ov;
        logic             multi_ov;
        logic             right2_ov;
        logic [POS_W-1:0] first_pos;
    } isim_stat_t;

endpackage

`default_nettype wire

@@ sv/interval_set_insert_merge_unit.sv @@
// Sorted set of up to 16 disjoint closed intervals held in a row of cells,
// one interval per cell. Clear, read and an insert that merges with at most
// one stored interval take an execute and a result state; an insert that
// merges more also runs the absorb state, as the row closes the gap left
// by each absorbed interval with one left shift per cycle. Results go
// through an output register, so the next item is taken while one waits.
// Depends on isim_pkg, isim_array, isim_cell and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "interval_set_insert_merge_unit_defines.svh"

module interval_set_insert_merge_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  new_start,
    input  logic signed [31:0]  new_end,
    input  logic [3:0]          read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  entry_start,
    output logic signed [31:0]  entry_end,
    output logic [4:0]          interval_count,
    output logic [1:0]          status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_ABSORB = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [1:0]                         op_reg;
    logic signed [isim_pkg::DATA_W-1:0] ns_reg;
    logic signed [isim_pkg::DATA_W-1:0] ne_reg;
    logic [3:0]                         idx_reg;
    logic [isim_pkg::CNT_W-1:0]         count_reg;
    logic [isim_pkg::CNT_W-1:0]         count_next;
    logic [isim_pkg::POS_W-1:0]         first_reg;
    logic [isim_pkg::POS_W-1:0]         first_next;
    logic signed [isim_pkg::DATA_W-1:0] res_start_reg;
    logic signed [isim_pkg::DATA_W-1:0] res_start_next;
    logic signed [isim_pkg::DATA_W-1:0] res_end_reg;
    logic signed [isim_pkg::DATA_W-1:0] res_end_next;
    logic [1:0]                         res_status_reg;
    logic [1:0]                         res_status_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [isim_pkg::DATA_W-1:0] out_start_reg;
    logic signed [isim_pkg::DATA_W-1:0] out_end_reg;
    logic [isim_pkg::CNT_W-1:0]         out_count_reg;
    logic [1:0]                         out_status_reg;

    logic                               accept;
    logic                               out_ok;
    logic                               out_load;
    logic                               full;
    logic                               ins_ok;
    logic                               idx_ok;
    isim_pkg::isim_ctrl_t               ctrl;
    isim_pkg::isim_stat_t               stat;
    logic signed [isim_pkg::DATA_W-1:0] rd_start;
    logic signed [isim_pkg::DATA_W-1:0] rd_end;

    assign out_ok   = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_RESULT) && out_ok;
    assign in_stall = !((state_reg == ST_IDLE) || out_load);
    assign accept   = in_valid && !in_stall;

    assign full   = count_reg == isim_pkg::CNT_W'(isim_pkg::MAX_INTERVALS);
    assign ins_ok = !(ns_reg > ne_reg);
    assign idx_ok = isim_pkg::CMP_W'(idx_reg) < isim_pkg::CMP_W'(count_reg);

    always_comb
    begin
        ctrl.mode      = isim_pkg::MODE_IDLE;
        ctrl.full      = full;
        ctrl.first_pos = first_reg;
        if (state_reg == ST_EXEC && op_reg == isim_pkg::OP_INSERT && ins_ok)
        begin
            ctrl.mode = isim_pkg::MODE_INSERT;
        end
        else if (state_reg == ST_ABSORB)
        begin
            ctrl.mode = isim_pkg::MODE_ABSORB;
        end
    end

    isim_array u_array (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .new_start  (ns_reg),
        .new_end    (ne_reg),
        .read_pos   (isim_pkg::POS_W'(idx_reg)),
        .stat       (stat),
        .read_start (rd_start),
        .read_end   (rd_end)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_start_next  = '0;
                res_end_next    = '0;
                res_status_next = isim_pkg::STATUS_OK;
                state_next      = ST_RESULT;
                case (op_reg)
                    isim_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    isim_pkg::OP_INSERT:
                    begin
                        if (!ins_ok)
                        begin
                            res_status_next = isim_pkg::STATUS_BAD_ORDER;
                        end
                        else if (!stat.any_ov)
                        begin
                            if (full)
                            begin
                                res_status_next = isim_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + isim_pkg::CNT_W'(1);
                            end
                        end
                        else if (stat.multi_ov)
                        begin
                            first_next = stat.first_pos;
                            state_next = ST_ABSORB;
                        end
                    end
                    isim_pkg::OP_READ:
                    begin
                        if (idx_ok)
                        begin
                            res_start_next = rd_start;
                            res_end_next   = rd_end;
                        end
                        else
                        begin
                            res_status_next = isim_pkg::STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        res_status_next = isim_pkg::STATUS_OK;
                    end
                endcase
            end
            ST_ABSORB:
            begin
                // one neighbor folded into the merged cell per cycle
                count_next = count_reg - isim_pkg::CNT_W'(1);
                if (!stat.right2_ov)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_ok)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            op_reg  <= operation;
            ns_reg  <= new_start;
            ne_reg  <= new_end;
            idx_reg <= read_index;
        end
        if (out_load)
        begin
            out_start_reg  <= res_start_reg;
            out_end_reg    <= res_end_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_start    = out_start_reg;
    assign entry_end      = out_end_reg;
    assign interval_count = 5'(out_count_reg);
    assign status         = out_status_reg;

    `ISIM_ASSERT(a_count_max, count_reg <= isim_pkg::CNT_W'(isim_pkg::MAX_INTERVALS), "count above capacity")
    `ISIM_ASSERT_NEXT(a_absorb_shrinks, state_reg == ST_ABSORB, count_reg == $past(count_reg) - isim_pkg::CNT_W'(1), "absorb step did not shrink the set")
    `ISIM_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC, "accepted item not executed next cycle")
    `ISIM_ASSERT(a_err_zero_entry, (out_valid_reg && out_status_reg != isim_pkg::STATUS_OK) |-> (out_start_reg == '0 && out_end_reg == '0), "error result carries entry data")

endmodule

`default_nettype wire

@@ sv/isim_cell.sv @@
// one storage cell of the interval row: holds one interval and compares it
// with the interval under insertion; depends on isim_pkg
`timescale 1ns / 1ps
`default_nettype none

module isim_cell (
    input  logic                                clk,
    input  logic [2:0]                          action,
    input  logic                                occupied,
    input  logic signed [isim_pkg::DATA_W-1:0]  new_start,
    input  logic signed [isim_pkg::DATA_W-1:0]  new_end,
    input  logic signed [isim_pkg::DATA_W-1:0]  left_start,
    input  logic signed [isim_pkg::DATA_W-1:0]  left_end,
    input  logic signed [isim_pkg::DATA_W-1:0]  right_start,
    input  logic signed [isim_pkg::DATA_W-1:0]  right_end,
    output isim_pkg::isim_flags_t               flags,
    output logic signed [isim_pkg::DATA_W-1:0]  cell_start,
    output logic signed [isim_pkg::DATA_W-1:0]  cell_end
);

    logic signed [isim_pkg::DATA_W-1:0] start_reg;
    logic signed [isim_pkg::DATA_W-1:0] start_next;
    logic signed [isim_pkg::DATA_W-1:0] end_reg;
    logic signed [isim_pkg::DATA_W-1:0] end_next;
    logic                               precedes;
    logic                               after;

    // an empty cell counts as lying after any interval
    assign precedes = occupied && (new_start > end_reg);
    assign after    = !occupied || (new_end < start_reg);

    assign flags.precedes = precedes;
    assign flags.overlap  = !precedes && !after;

    assign cell_start = start_reg;
    assign cell_end   = end_reg;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        case (action)
            isim_pkg::ACT_LOAD_NEW:
            begin
                start_next = new_start;
                end_next   = new_end;
            end
            isim_pkg::ACT_FROM_LEFT:
            begin
                start_next = left_start;
                end_next   = left_end;
            end
            isim_pkg::ACT_MERGE_NEW:
            begin
                start_next = (new_start < start_reg) ? new_start : start_reg;
                end_next   = (new_end > end_reg) ? new_end : end_reg;
            end
            // right neighbor always starts later, so only the end can grow
            isim_pkg::ACT_ABSORB_RIGHT:
            begin
                end_next = (right_end > end_reg) ? right_end : end_reg;
            end
            isim_pkg::ACT_FROM_RIGHT:
            begin
                start_next = right_start;
                end_next   = right_end;
            end
            default:
            begin
                start_next = start_reg;
                end_next   = end_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

endmodule

`default_nettype wire

@@ sv/isim_array.sv @@
// row of isim_cell instances with the per-cell action decode, overlap
// summary and read select; depends on isim_pkg and isim_cell
`timescale 1ns / 1ps
`default_nettype none

module isim_array (
    input  logic                                clk,
    input  isim_pkg::isim_ctrl_t                ctrl,
    input  logic [isim_pkg::CNT_W-1:0]          count,
    input  logic signed [isim_pkg::DATA_W-1:0]  new_start,
    input  logic signed [isim_pkg::DATA_W-1:0]  new_end,
    input  logic [isim_pkg::POS_W-1:0]          read_pos,
    output isim_pkg::isim_stat_t                stat,
    output logic signed [isim_pkg::DATA_W-1:0]  read_start,
    output logic signed [isim_pkg::DATA_W-1:0]  read_end
);

    localparam int N = isim_pkg::MAX_INTERVALS;

    logic signed [isim_pkg::DATA_W-1:0] cs [N];
    logic signed [isim_pkg::DATA_W-1:0] ce [N];
    isim_pkg::isim_flags_t              fl [N];
    logic [2:0]                         act [N];
    logic [N-1:0]                       occ;
    logic [N-1:0]                       ov_vec;
    logic [N-1:0]                       bef_vec;
    logic [N-1:0]                       bef_prev;
    logic [N-1:0]                       first_oh;
    logic [N-1:0]                       sel;
    logic [N-1:0]                       le_mask;
    logic [N-1:0]                       gt_mask;
    logic [isim_pkg::POS_W-1:0]         first_idx;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic signed [isim_pkg::DATA_W-1:0] ls;
            logic signed [isim_pkg::DATA_W-1:0] le;
            logic signed [isim_pkg::DATA_W-1:0] rs;
            logic signed [isim_pkg::DATA_W-1:0] re;

            if (g == 0)
            begin : g_first
                assign ls = '0;
                assign le = '0;
            end
            else
            begin : g_mid_l
                assign ls = cs[g-1];
                assign le = ce[g-1];
            end

            if (g == N - 1)
            begin : g_last
                assign rs = '0;
                assign re = '0;
            end
            else
            begin : g_mid_r
                assign rs = cs[g+1];
                assign re = ce[g+1];
            end

            assign occ[g]     = isim_pkg::CNT_W'(g) < count;
            assign ov_vec[g]  = fl[g].overlap;
            assign bef_vec[g] = fl[g].precedes;

            isim_cell u_cell (
                .clk         (clk),
                .action      (act[g]),
                .occupied    (occ[g]),
                .new_start   (new_start),
                .new_end     (new_end),
                .left_start  (ls),
                .left_end    (le),
                .right_start (rs),
                .right_end   (re),
                .flags       (fl[g]),
                .cell_start  (cs[g]),
                .cell_end    (ce[g])
            );
        end
    endgenerate

    // cell 0 has nothing on its left, so it counts as following a preceding cell
    assign bef_prev = {bef_vec[N-2:0], 1'b1};
    assign first_oh = ov_vec & ~(ov_vec << 1);
    assign sel      = {{(N-1){1'b0}}, 1'b1} << ctrl.first_pos;
    // cells at or below the merge position; wraps to all ones for the top cell
    assign le_mask  = (sel << 1) - {{(N-1){1'b0}}, 1'b1};
    assign gt_mask  = ~le_mask;

    always_comb
    begin
        first_idx = '0;
        for (int j = 0; j < N; j++)
        begin
            if (first_oh[j])
            begin
                first_idx = first_idx | isim_pkg::POS_W'(j);
            end
        end
    end

    assign stat.any_ov    = |ov_vec;
    assign stat.multi_ov  = |(ov_vec & (ov_vec << 1));
    assign stat.right2_ov = |(ov_vec & (sel << 2));
    assign stat.first_pos = first_idx;

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            act[j] = isim_pkg::ACT_HOLD;
            case (ctrl.mode)
                isim_pkg::MODE_INSERT:
                begin
                    if (!stat.any_ov)
                    begin
                        // plain insert: open a slot and shift the tail right
                        if (ctrl.full || bef_vec[j])
                        begin
                            act[j] = isim_pkg::ACT_HOLD;
                        end
                        else if (bef_prev[j])
                        begin
                            act[j] = isim_pkg::ACT_LOAD_NEW;
                        end
                        else
                        begin
                            act[j] = isim_pkg::ACT_FROM_LEFT;
                        end
                    end
                    else if (first_oh[j])
                    begin
                        act[j] = isim_pkg::ACT_MERGE_NEW;
                    end
                end
                isim_pkg::MODE_ABSORB:
                begin
                    if (sel[j])
                    begin
                        act[j] = isim_pkg::ACT_ABSORB_RIGHT;
                    end
                    else if (gt_mask[j])
                    begin
                        act[j] = isim_pkg::ACT_FROM_RIGHT;
                    end
                end
                default:
                begin
                    act[j] = isim_pkg::ACT_HOLD;
                end
            endcase
        end
    end

    assign read_start = cs[read_pos];
    assign read_end   = ce[read_pos];

endmodule

`default_nettype wire
